### hw/rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg: shared types and constants for the axis-angle vector rotation
// Holds the beat payload types, the CORDIC step count and the arctangent table.
// ----------------------------------------------------------------------------
package aavr_pkg;

	localparam int unsigned CordicSteps = 20;
	localparam logic signed [33:0] CordicX0 = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [15:0] kx;
		logic signed [15:0] ky;
		logic signed [15:0] kz;
		logic [1:0]         quad;
	} item_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
	} cordic_t;

	function automatic logic signed [31:0] atan_turn(input int unsigned step);
		logic signed [31:0] r;
		case (step)
			0:       r = 32'sh20000000;
			1:       r = 32'sh12E4051E;
			2:       r = 32'sh09FB385B;
			3:       r = 32'sh051111D4;
			4:       r = 32'sh028B0D43;
			5:       r = 32'sh0145D7E1;
			6:       r = 32'sh00A2F61E;
			7:       r = 32'sh00517C55;
			8:       r = 32'sh0028BE53;
			9:       r = 32'sh00145F2F;
			10:      r = 32'sh000A2F98;
			11:      r = 32'sh000517CC;
			12:      r = 32'sh00028BE6;
			13:      r = 32'sh000145F3;
			14:      r = 32'sh0000A2FA;
			15:      r = 32'sh0000517D;
			16:      r = 32'sh000028BE;
			17:      r = 32'sh0000145F;
			18:      r = 32'sh00000A30;
			19:      r = 32'sh00000518;
			default: r = 32'sh00000000;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/aavr_cordic_cell.sv
// ----------------------------------------------------------------------------
// aavr_cordic_cell: one rotation step of the CORDIC chain
// Performs a single micro-rotation and passes the beat payload to the next cell.
// ----------------------------------------------------------------------------
module aavr_cordic_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  aavr_pkg::cordic_t cor_in,
	input  aavr_pkg::item_t   item_in,
	output logic              vld_q,
	output aavr_pkg::cordic_t cor_q,
	output aavr_pkg::item_t   item_q
);

	logic signed [33:0] xs;
	logic signed [33:0] ys;
	aavr_pkg::cordic_t  nxt;

	always_comb begin
		xs = cor_in.x >>> STEP;
		ys = cor_in.y >>> STEP;
		if (cor_in.z >= 0) begin
			nxt.x = cor_in.x - ys;
			nxt.y = cor_in.y + xs;
			nxt.z = cor_in.z - aavr_pkg::atan_turn(STEP);
		end else begin
			nxt.x = cor_in.x + ys;
			nxt.y = cor_in.y - xs;
			nxt.z = cor_in.z + aavr_pkg::atan_turn(STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		cor_q  <= nxt;
		item_q <= item_in;
	end

endmodule

### hw/rtl/aavr_combine.sv
// ----------------------------------------------------------------------------
// aavr_combine: Rodrigues combination of sine, cosine, axis and vector
// Six pipeline stages of products, rounding and saturation.
// ----------------------------------------------------------------------------
module aavr_combine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  aavr_pkg::cordic_t cor_in,
	input  aavr_pkg::item_t   item_in,
	output logic              done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: sine and cosine in Q2.28, axis-vector products.
	logic signed [32:0] xr, yr;
	logic signed [31:0] c_n, s_n;
	logic signed [31:0] c_s1, s_s1;
	logic signed [47:0] kxvx_s1, kyvy_s1, kzvz_s1, kyvz_s1, kzvy_s1;
	logic signed [47:0] kzvx_s1, kxvz_s1, kxvy_s1, kyvx_s1;
	aavr_pkg::item_t    it_s1;

	always_comb begin
		xr = (33'(cor_in.x) + 33'sd2) >>> 2;
		yr = (33'(cor_in.y) + 33'sd2) >>> 2;
		case (item_in.quad)
			2'd0:    begin c_n = xr[31:0];  s_n = yr[31:0];  end
			2'd1:    begin c_n = -yr[31:0]; s_n = xr[31:0];  end
			2'd2:    begin c_n = -xr[31:0]; s_n = -yr[31:0]; end
			default: begin c_n = yr[31:0];  s_n = -xr[31:0]; end
		endcase
	end

	always_ff @(posedge clk) begin
		c_s1    <= c_n;
		s_s1    <= s_n;
		kxvx_s1 <= item_in.kx * item_in.vx;
		kyvy_s1 <= item_in.ky * item_in.vy;
		kzvz_s1 <= item_in.kz * item_in.vz;
		kyvz_s1 <= item_in.ky * item_in.vz;
		kzvy_s1 <= item_in.kz * item_in.vy;
		kzvx_s1 <= item_in.kz * item_in.vx;
		kxvz_s1 <= item_in.kx * item_in.vz;
		kxvy_s1 <= item_in.kx * item_in.vy;
		kyvx_s1 <= item_in.ky * item_in.vx;
		it_s1   <= item_in;
	end

	// Stage 2: dot and cross products rounded to Q16.16, one minus cosine.
	logic signed [49:0] dot_n, cxs_n, cys_n, czs_n;
	logic signed [35:0] dot_s2, cx_s2, cy_s2, cz_s2;
	logic signed [31:0] c_s2, s_s2, omc_s2;
	aavr_pkg::item_t    it_s2;

	always_comb begin
		dot_n = 50'(kxvx_s1) + 50'(kyvy_s1) + 50'(kzvz_s1) + 50'sd8192;
		cxs_n = 50'(kyvz_s1) - 50'(kzvy_s1) + 50'sd8192;
		cys_n = 50'(kzvx_s1) - 50'(kxvz_s1) + 50'sd8192;
		czs_n = 50'(kxvy_s1) - 50'(kyvx_s1) + 50'sd8192;
	end

	always_ff @(posedge clk) begin
		dot_s2 <= 36'(dot_n >>> 14);
		cx_s2  <= 36'(cxs_n >>> 14);
		cy_s2  <= 36'(cys_n >>> 14);
		cz_s2  <= 36'(czs_n >>> 14);
		omc_s2 <= 32'sh10000000 - c_s1;
		c_s2   <= c_s1;
		s_s2   <= s_s1;
		it_s2  <= it_s1;
	end

	// Stage 3: products with cosine, sine and one minus cosine.
	logic signed [67:0] mw_s3, pcx_s3, pcy_s3, pcz_s3;
	logic signed [63:0] pvx_s3, pvy_s3, pvz_s3;
	aavr_pkg::item_t    it_s3;

	always_ff @(posedge clk) begin
		mw_s3  <= 68'(dot_s2) * 68'(omc_s2);
		pcx_s3 <= 68'(cx_s2) * 68'(s_s2);
		pcy_s3 <= 68'(cy_s2) * 68'(s_s2);
		pcz_s3 <= 68'(cz_s2) * 68'(s_s2);
		pvx_s3 <= it_s2.vx * c_s2;
		pvy_s3 <= it_s2.vy * c_s2;
		pvz_s3 <= it_s2.vz * c_s2;
		it_s3  <= it_s2;
	end

	// Stage 4: round the products back to Q16.16.
	logic signed [67:0] mw_r, cx_r, cy_r, cz_r;
	logic signed [63:0] vx_r, vy_r, vz_r;
	logic signed [39:0] w_s4, tcx_s4, tcy_s4, tcz_s4, tvx_s4, tvy_s4, tvz_s4;
	aavr_pkg::item_t    it_s4;

	always_comb begin
		mw_r = (mw_s3 + 68'sd134217728) >>> 28;
		cx_r = (pcx_s3 + 68'sd134217728) >>> 28;
		cy_r = (pcy_s3 + 68'sd134217728) >>> 28;
		cz_r = (pcz_s3 + 68'sd134217728) >>> 28;
		vx_r = (pvx_s3 + 64'sd134217728) >>> 28;
		vy_r = (pvy_s3 + 64'sd134217728) >>> 28;
		vz_r = (pvz_s3 + 64'sd134217728) >>> 28;
	end

	always_ff @(posedge clk) begin
		w_s4   <= 40'(mw_r);
		tcx_s4 <= 40'(cx_r);
		tcy_s4 <= 40'(cy_r);
		tcz_s4 <= 40'(cz_r);
		tvx_s4 <= 40'(vx_r);
		tvy_s4 <= 40'(vy_r);
		tvz_s4 <= 40'(vz_r);
		it_s4  <= it_s3;
	end

	// Stage 5: axis times the scaled dot product, partial sums.
	logic signed [55:0] kwx_s5, kwy_s5, kwz_s5;
	logic signed [40:0] ax_s5, ay_s5, az_s5;

	always_ff @(posedge clk) begin
		kwx_s5 <= 56'(it_s4.kx) * 56'(w_s4);
		kwy_s5 <= 56'(it_s4.ky) * 56'(w_s4);
		kwz_s5 <= 56'(it_s4.kz) * 56'(w_s4);
		ax_s5  <= 41'(tvx_s4) + 41'(tcx_s4);
		ay_s5  <= 41'(tvy_s4) + 41'(tcy_s4);
		az_s5  <= 41'(tvz_s4) + 41'(tcz_s4);
	end

	// Stage 6: final sum and saturation.
	logic signed [55:0] sx, sy, sz;

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -56'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	always_comb begin
		sx = 56'(ax_s5) + ((kwx_s5 + 56'sd8192) >>> 14);
		sy = 56'(ay_s5) + ((kwy_s5 + 56'sd8192) >>> 14);
		sz = 56'(az_s5) + ((kwz_s5 + 56'sd8192) >>> 14);
	end

	always_ff @(posedge clk) begin
		rot_x <= sat32(sx);
		rot_y <= sat32(sy);
		rot_z <= sat32(sz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign done = v_s6;

endmodule

### hw/rtl/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation: rotate a vector about a unit axis by an angle
// Rodrigues rotation with a pipelined chain of CORDIC cells for sine/cosine.
//
// Channel   Handshake        Payload
// input     start / busy     vec_x/y/z, axis_x/y/z, turn_angle
// output    done (strobe)    rot_x/y/z
//
// A beat is taken in every cycle; busy is always low.
// The pipeline has one input register, twenty CORDIC cells and six
// combine stages. Reset clears only the valid bits of the pipeline.
// The receiver cannot stall; each result appears for one cycle with done.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic [15:0]        turn_angle,
	output logic               done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);

	localparam int unsigned N = aavr_pkg::CordicSteps;

	logic              vld [0:N];
	aavr_pkg::cordic_t cor [0:N];
	aavr_pkg::item_t   itm [0:N];

	logic [15:0]        shifted;
	logic [1:0]         quad_n;
	logic signed [15:0] resid;
	aavr_pkg::item_t    item_n;

	function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] a);
		logic signed [15:0] r;
		if (a > 16'sd16384) begin
			r = 16'sd16384;
		end else if (a < -16'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = a;
		end
		return r;
	endfunction

	always_comb begin
		shifted     = turn_angle + 16'h2000;
		quad_n      = shifted[15:14];
		resid       = {turn_angle[15:14] - quad_n, turn_angle[13:0]};
		item_n.vx   = vec_x;
		item_n.vy   = vec_y;
		item_n.vz   = vec_z;
		item_n.kx   = clamp_axis(axis_x);
		item_n.ky   = clamp_axis(axis_y);
		item_n.kz   = clamp_axis(axis_z);
		item_n.quad = quad_n;
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else begin
			vld[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cor[0].x <= aavr_pkg::CordicX0;
		cor[0].y <= 34'sd0;
		cor[0].z <= {resid, 16'h0000};
		itm[0]   <= item_n;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		aavr_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (vld[i]),
			.cor_in (cor[i]),
			.item_in(itm[i]),
			.vld_q  (vld[i+1]),
			.cor_q  (cor[i+1]),
			.item_q (itm[i+1])
		);
	end

	aavr_combine u_combine (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld[N]),
		.cor_in (cor[N]),
		.item_in(itm[N]),
		.done   (done),
		.rot_x  (rot_x),
		.rot_y  (rot_y),
		.rot_z  (rot_z)
	);

`ifndef NO_ASSERTIONS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 27))
		else $error("result beat without a matching accepted beat");
	a_cell_chain_delay: assert property (@(posedge clk) disable iff (!arst_n)
		vld[N] |-> $past(vld[0], N))
		else $error("CORDIC chain valid out of step");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for axis_angle_vector_rotation
// Directed and random rotations are fed through the start/busy port, and every
// done beat is checked against a fixed-point Rodrigues predictor run in the
// bench, with its own CORDIC sine and cosine.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] vec_x, vec_y, vec_z;
	logic signed [15:0] axis_x, axis_y, axis_z;
	logic [15:0]        turn_angle;
	logic               done;
	logic signed [31:0] rot_x, rot_y, rot_z;

	vec3_t       rotated_q[$];
	int          idle_pct;
	int          n_sent;
	int          n_checked;
	int          n_errors;
	longint      cycles;

	localparam longint CycleLimit = 200000;
	localparam int     Latency    = 27;

	axis_angle_vector_rotation DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.turn_angle(turn_angle), .done(done),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint floor_sh(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint round_sh(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp_k(logic signed [15:0] a);
		if (a > 16384) return 16384;
		if (a < -16384) return -16384;
		return longint'(a);
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic vec3_t rotate_vector(logic signed [31:0] vx_i, logic signed [31:0] vy_i,
			logic signed [31:0] vz_i, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic [15:0] ang);
		logic [1:0]         quad;
		logic signed [15:0] resid;
		longint             x, y, z, nx, ny, c, s, vx, vy, vz, kx, ky, kz;
		longint             dot, w, cx, cy, cz;
		vec3_t              r;
		quad  = 2'((32'(ang) + 32'h2000) >> 14);
		resid = 16'(ang - {quad, 14'd0});
		z = longint'(resid) * 65536;
		x = longint'(aavr_pkg::CordicX0);
		y = 0;
		for (int i = 0; i < aavr_pkg::CordicSteps; i++) begin
			if (z >= 0) begin
				nx = x - floor_sh(y, i);
				ny = y + floor_sh(x, i);
				z -= longint'(aavr_pkg::atan_turn(i));
			end else begin
				nx = x + floor_sh(y, i);
				ny = y - floor_sh(x, i);
				z += longint'(aavr_pkg::atan_turn(i));
			end
			x = nx;
			y = ny;
		end
		x = round_sh(x, 2);
		y = round_sh(y, 2);
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		vx = longint'(vx_i); vy = longint'(vy_i); vz = longint'(vz_i);
		kx = clamp_k(ax); ky = clamp_k(ay); kz = clamp_k(az);
		dot = kx * vx + ky * vy + kz * vz;
		w  = round_sh(round_sh(dot, 14) * ((64'sd1 <<< 28) - c), 28);
		cx = round_sh(ky * vz - kz * vy, 14);
		cy = round_sh(kz * vx - kx * vz, 14);
		cz = round_sh(kx * vy - ky * vx, 14);
		r.x = sat32(round_sh(vx * c, 28) + round_sh(cx * s, 28) + round_sh(kx * w, 14));
		r.y = sat32(round_sh(vy * c, 28) + round_sh(cy * s, 28) + round_sh(ky * w, 14));
		r.z = sat32(round_sh(vz * c, 28) + round_sh(cz * s, 28) + round_sh(kz * w, 14));
		return r;
	endfunction

	task automatic send_rotation(logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic [15:0] ang);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		vec_x      <= vx;
		vec_y      <= vy;
		vec_z      <= vz;
		axis_x     <= ax;
		axis_y     <= ay;
		axis_z     <= az;
		turn_angle <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
		rotated_q.push_back(rotate_vector(vx, vy, vz, ax, ay, az, ang));
		n_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		vec3_t e;
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected done beat, rot = %h %h %h", $time,
					rot_x, rot_y, rot_z);
				n_errors++;
			end else begin
				e = rotated_q.pop_front();
				n_checked++;
				if (rot_x !== e.x) begin
					$display("%0t: rot_x expected %h actual %h", $time, e.x, rot_x);
					n_errors++;
				end
				if (rot_y !== e.y) begin
					$display("%0t: rot_y expected %h actual %h", $time, e.y, rot_y);
					n_errors++;
				end
				if (rot_z !== e.z) begin
					$display("%0t: rot_z expected %h actual %h", $time, e.z, rot_z);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("** axis_angle_vector_rotation: FAILED **");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_axis_comp();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic logic signed [31:0] rand_vec_comp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
			2: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(255)
				: 32'sh80000000 + $urandom_range(255);
			default: return 32'($signed($urandom_range(65535)) - 32768);
		endcase
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (rotated_q.size() != 0) @(negedge clk);
		repeat (Latency + 3) @(negedge clk);
	endtask

	task automatic test_directed();
		logic [15:0] angles[8] = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000,
			16'h6000, 16'h8000, 16'hC000, 16'hFFFF};
		foreach (angles[i])
			send_rotation(32'sh00010000, 32'sh00020000, -32'sh00030000,
				16'sd0, 16'sd0, 16'sd16384, angles[i]);
		send_rotation(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			16'sd9459, 16'sd9459, 16'sd9459, 16'h2000);
		send_rotation(32'sh80000000, 32'sh80000000, 32'sh80000000,
			-16'sd16384, 16'sd0, 16'sd0, 16'h8000);
		send_rotation(32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000,
			16'sd0, 16'sd0, -16'sd16384, 16'h4000);
		send_rotation(32'sh12345678, -32'sh0ABCDEF0, 32'sh7FFFFFFF,
			16'sh7FFF, 16'sh8000, 16'sd20000, 16'h3000);
		send_rotation(32'sh00010000, 32'sh00010000, 32'sh00010000,
			16'sd16384, 16'sd16384, 16'sd16384, 16'h1000);
		send_rotation(32'sh00000000, 32'sh00000000, 32'sh00000000,
			16'sd0, 16'sd0, 16'sd0, 16'h5555);
		send_rotation(-32'sd1, 32'sd1, -32'sd1, 16'sh8000, 16'sh7FFF, 16'sh0001, 16'hFFFF);
		send_rotation(32'sh55555555, 32'shAAAAAAAA, 32'sh0000FFFF,
			16'sd16384, 16'sd0, 16'sd0, 16'hE000);
	endtask

	task automatic test_random(int n, int pct);
		logic signed [15:0] ax, ay, az;
		idle_pct = pct;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin ax = 16'sd16384; ay = 16'sd0; az = 16'sd0; end
				1: begin ax = rand_axis_comp(); ay = rand_axis_comp(); az = rand_axis_comp(); end
				2: begin ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom); end
				default: begin
					ax = 16'sd0;
					ay = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
					az = 16'sd0;
				end
			endcase
			send_rotation(rand_vec_comp(), rand_vec_comp(), rand_vec_comp(),
				ax, ay, az, 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0; start = 1'b0;
		vec_x = 0; vec_y = 0; vec_z = 0;
		axis_x = 0; axis_y = 0; axis_z = 0; turn_angle = 0;
		idle_pct = 17; n_sent = 0; n_checked = 0; n_errors = 0; cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(200, 17);
		wait_drained();
		test_random(200, 76);
		test_random(230, 0);
		wait_drained();
		$display("Checked %0d of %0d rotations: quadrant edges, saturation, clamped", n_checked, n_sent);
		$display("and non-unit axes, random vectors under three idle patterns.");
		if (n_errors == 0) begin
			$display("** axis_angle_vector_rotation: PASSED **");
		end else begin
			$display("** axis_angle_vector_rotation: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/aavr_pkg.sv
hw/rtl/aavr_cordic_cell.sv
hw/rtl/aavr_combine.sv
hw/rtl/axis_angle_vector_rotation.sv
test/tb_top.sv
